// File: hw/rtl/prime_sequence_generator_assert.svh
// Assertion macros shared by the prime sequence generator RTL.
`ifndef PRIME_SEQUENCE_GENERATOR_ASSERT_SVH
`define PRIME_SEQUENCE_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define PSG_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define PSG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PSG_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`define PSG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/psg_pkg.sv
// Package with the fixed widths and constants of the prime sequence generator.
package psg_pkg;

   localparam int COUNT_W = 17;
   localparam int PRIME_W = 20;
   localparam int NUM_FIXED = 3;
   localparam int FIRST_TRIAL_IDX = 2;
   localparam int FIRST_TRIAL_PRIME = 5;
   localparam int CAND_START = 7;
   localparam logic [COUNT_W-1:0] TARGET_RESET = 17'd1024;

   function automatic logic [PRIME_W-1:0] first_prime(input logic [1:0] idx);
      logic [PRIME_W-1:0] value;
      unique case (idx)
         2'd0: value = 20'd2;
         2'd1: value = 20'd3;
         2'd2: value = 20'd5;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

// File: hw/rtl/psg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psg_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/psg_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module psg_divider #(
   parameter int WIDTH = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] trial;

   assign trial = {rem_ff[WIDTH-2:0], quo_ff[WIDTH-1]};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= den_ff) begin
            rem_in = trial - den_ff;
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: hw/rtl/prime_sequence_generator.sv
// Top level of the prime sequence generator with its trial-division sequencer.
//
// Each request transaction returns one response transaction holding the next prime
// in ascending order and its one-based position. A request with restart set clears
// the sequence first and is answered with the prime 2. Once target_count primes have
// been given, the table is full or the candidate outgrows PRIME_BITS, the response
// carries done_res set with prime and position at zero.
// The csr port writes target_count; write it only while no request is in flight.
// The first three primes come from constants: the request passes ST_CHECK and ST_FINISH
// before the response is registered, and the next request can be accepted from then on.
// Later primes come from trial division of the candidate by the stored primes from 5
// up to its square root. Every trial is one pass of a shared bit-serial divider,
// followed by ST_DECIDE and, for a further trial, ST_FETCH to read the next stored prime.
// A candidate near 2^20 needs up to about 170 trials, and every composite candidate
// skipped on the way adds its own trials. With the default table the largest prime is
// 8161.
// The block accepts one request at a time; req_ready is high while it waits for
// the next request, also while the previous response still waits in the output
// register. A stalled receiver holds the finished result until the output
// register frees. Reset clears the sequence and sets target_count to 1024.
`include "prime_sequence_generator_assert.svh"

module prime_sequence_generator #(
   parameter int MAX_PRIMES = 1024,
   parameter int PRIME_BITS = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_restart,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [psg_pkg::PRIME_W-1:0]  rsp_prime,
   output logic [psg_pkg::COUNT_W-1:0]  rsp_position,
   output logic                         rsp_done_res,
   input  logic                         csr_wr_en,
   input  logic [psg_pkg::COUNT_W-1:0]  csr_wr_data
);

   import psg_pkg::*;

   localparam int AW = $clog2(MAX_PRIMES);
   localparam int CW = PRIME_BITS + 1;
   localparam logic [CW-1:0] CAND_MASK = {1'b0, {PRIME_BITS{1'b1}}};
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PRIMES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CAND,
      ST_DIV,
      ST_DECIDE,
      ST_FETCH,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    target_ff, target_in;
   logic [CW-1:0]         cand_ff, cand_in;
   logic                  step4_ff, step4_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    k_ff, k_in;
   logic [PRIME_BITS-1:0] divisor_ff, divisor_in;
   logic [PRIME_W-1:0]    res_prime_ff, res_prime_in;
   logic [COUNT_W-1:0]    res_pos_ff, res_pos_in;
   logic                  res_done_ff, res_done_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PRIME_W-1:0]    rsp_prime_ff, rsp_prime_in;
   logic [COUNT_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic [CW-1:0]         cand_next;
   logic [COUNT_W-1:0]    k_next;
   logic [COUNT_W-1:0]    count_next;
   logic                  div_start;
   logic [PRIME_BITS-1:0] div_divisor;
   logic                  div_busy;
   logic                  div_done;
   logic [CW-1:0]         div_quot;
   logic [CW-1:0]         div_rem;
   logic                  ram_we;
   logic                  ram_re;
   logic [PRIME_BITS-1:0] ram_rd_data;

   assign cand_next  = cand_ff + (step4_ff ? CW'(4) : CW'(2));
   assign k_next     = k_ff + COUNT_W'(1);
   assign count_next = count_ff + COUNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      cand_in      = cand_ff;
      step4_in     = step4_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      divisor_in   = divisor_ff;
      res_prime_in = res_prime_ff;
      res_pos_in   = res_pos_ff;
      res_done_in  = res_done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_done_in  = rsp_done_ff;
      div_start    = 1'b0;
      div_divisor  = divisor_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      if (csr_wr_en) begin
         target_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  cand_in  = CW'(CAND_START);
                  step4_in = 1'b1;
                  count_in = '0;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (count_ff >= target_ff || count_ff >= MAX_COUNT || cand_ff > CAND_MASK) begin
               res_prime_in = '0;
               res_pos_in   = '0;
               res_done_in  = 1'b1;
               state_in     = ST_FINISH;
            end else if (count_ff < COUNT_W'(NUM_FIXED)) begin
               res_prime_in = first_prime(count_ff[1:0]);
               res_pos_in   = count_next;
               res_done_in  = 1'b0;
               count_in     = count_next;
               state_in     = ST_FINISH;
            end else begin
               state_in = ST_CAND;
            end
         end
         ST_CAND: begin
            if (cand_ff > CAND_MASK) begin
               res_prime_in = '0;
               res_pos_in   = '0;
               res_done_in  = 1'b1;
               state_in     = ST_FINISH;
            end else begin
               k_in        = COUNT_W'(FIRST_TRIAL_IDX);
               divisor_in  = PRIME_BITS'(FIRST_TRIAL_PRIME);
               div_divisor = PRIME_BITS'(FIRST_TRIAL_PRIME);
               div_start   = 1'b1;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (div_rem == '0) begin
               cand_in  = cand_next;
               step4_in = !step4_ff;
               state_in = ST_CAND;
            end else if ({1'b0, divisor_ff} > div_quot || k_next >= count_ff) begin
               ram_we       = 1'b1;
               res_prime_in = PRIME_W'(cand_ff[PRIME_BITS-1:0]);
               res_pos_in   = count_next;
               res_done_in  = 1'b0;
               count_in     = count_next;
               cand_in      = cand_next;
               step4_in     = !step4_ff;
               state_in     = ST_FINISH;
            end else begin
               k_in     = k_next;
               ram_re   = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            divisor_in  = ram_rd_data;
            div_divisor = ram_rd_data;
            div_start   = 1'b1;
            state_in    = ST_DIV;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = res_prime_ff;
               rsp_pos_in   = res_pos_ff;
               rsp_done_in  = res_done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      divisor_ff   <= divisor_in;
      k_ff         <= k_in;
      res_prime_ff <= res_prime_in;
      res_pos_ff   <= res_pos_in;
      res_done_ff  <= res_done_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_done_ff  <= rsp_done_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= TARGET_RESET;
         cand_ff      <= CW'(CAND_START);
         step4_ff     <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         cand_ff      <= cand_in;
         step4_ff     <= step4_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   psg_divider #(
      .WIDTH(CW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cand_ff),
      .divisor   ({1'b0, div_divisor}),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   psg_ram #(
      .WIDTH(PRIME_BITS),
      .DEPTH(MAX_PRIMES)
   ) u_prime_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (cand_ff[PRIME_BITS-1:0]),
      .rd_en   (ram_re),
      .rd_addr (k_next[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_prime    = rsp_prime_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_done_res = rsp_done_ff;

   `PSG_ASSERT_IMPLY(a_done_is_empty, clock, reset, rsp_valid_ff && rsp_done_ff, rsp_prime_ff == '0 && rsp_pos_ff == '0, "Done response carries a prime or position.")
   `PSG_ASSERT_IMPLY(a_prime_has_pos, clock, reset, rsp_valid_ff && !rsp_done_ff, rsp_pos_ff != '0 && rsp_pos_ff <= MAX_COUNT, "Prime response has a bad position.")
   `PSG_ASSERT_IMPLY(a_trial_index, clock, reset, state_ff == ST_DECIDE, k_ff >= COUNT_W'(FIRST_TRIAL_IDX) && k_ff < count_ff, "Trial index outside the stored primes.")
   `PSG_ASSERT_IMPLY(a_div_idle_start, clock, reset, div_start, !div_busy, "Divider started while busy.")
   `PSG_ASSERT_NEXT(a_div_runs, clock, reset, div_start, div_busy && state_ff == ST_DIV, "Divider did not start a division.")

endmodule
